@@ src/tier_placement_planner_defines.svh @@
// Assertion macros for the tier placement planner.
// Included by the top level; expects clk and rst_n in scope.
`ifndef TIER_PLACEMENT_PLANNER_DEFINES_SVH
`define TIER_PLACEMENT_PLANNER_DEFINES_SVH

// same-cycle implication
`define TPP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/tpp_pkg.sv @@
// Shared types and constants for the tier placement planner.
// No dependencies.
`default_nettype none

package tpp_pkg;

    localparam int TIER_ID_BITS_DEF    = 8;
    localparam int BYTE_COUNT_BITS_DEF = 48;
    localparam int KEY_BITS            = 32;
    localparam int COPY_BITS           = 4;
    localparam int FAST_ID_BITS        = 8;
    localparam int WM_BITS             = 17;
    localparam int WM_FRAC_BITS        = 16;
    localparam int CFG_DATA_BITS       = 17;
    localparam int CFG_INDEX_BITS      = 2;

    localparam logic [WM_BITS-1:0] WM_ONE         = 17'd65536;
    localparam logic [WM_BITS-1:0] HIGH_WM_RESET  = 17'd58982;
    localparam logic [WM_BITS-1:0] LOW_WM_RESET   = 17'd45875;

    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_KEY   = 1'b1;

    typedef enum logic [1:0] {
        ACT_NONE      = 2'd0,
        ACT_EVICT     = 2'd1,
        ACT_MIGRATE   = 2'd2,
        ACT_REPLICATE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_PARAMS = 2'd1,
        ST_NO_TIER    = 2'd2,
        ST_NO_REPLICA = 2'd3
    } status_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_FAST_TIER_ID  = 2'd0,
        CFG_FAST_TIER_SET = 2'd1,
        CFG_HIGH_WM       = 2'd2,
        CFG_LOW_WM        = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [FAST_ID_BITS-1:0] fast_tier_id;
        logic                    fast_tier_set;
        logic [WM_BITS-1:0]      high_wm;
        logic [WM_BITS-1:0]      low_wm;
    } cfg_t;

endpackage

`default_nettype wire

@@ src/tpp_ratio_stage.sv @@
// Second pipeline stage: scales total capacity by both watermarks.
// Depends on tpp_pkg.
`default_nettype none

module tpp_ratio_stage #(
    parameter int TIER_ID_BITS    = tpp_pkg::TIER_ID_BITS_DEF,
    parameter int BYTE_COUNT_BITS = tpp_pkg::BYTE_COUNT_BITS_DEF
) (
    input  wire                                       clk,
    input  wire                                       rst_n,
    input  tpp_pkg::cfg_t                             cfg,
    input  wire                                       s1_valid,
    input  wire                                       s2_ready,
    input  wire                                       s1_command,
    input  wire  [BYTE_COUNT_BITS-1:0]                s1_used,
    input  wire  [BYTE_COUNT_BITS-1:0]                s1_total,
    input  wire                                       s1_fast_stats,
    input  wire                                       s1_slow_present,
    input  wire  [TIER_ID_BITS-1:0]                   s1_slow_tier,
    input  wire  [tpp_pkg::KEY_BITS-1:0]              s1_key,
    input  wire  [BYTE_COUNT_BITS-1:0]                s1_size,
    input  wire                                       s1_in_fast,
    input  wire  [tpp_pkg::COPY_BITS-1:0]             s1_copies,
    input  wire  [TIER_ID_BITS-1:0]                   s1_first,
    output logic                                      s2_valid,
    output logic                                      s2_command,
    output logic [BYTE_COUNT_BITS-1:0]                s2_used,
    output logic                                      s2_total_zero,
    output logic [BYTE_COUNT_BITS+tpp_pkg::WM_BITS-1:0] s2_high_prod,
    output logic [BYTE_COUNT_BITS+tpp_pkg::WM_BITS-1:0] s2_low_prod,
    output logic                                      s2_fast_stats,
    output logic                                      s2_slow_present,
    output logic [TIER_ID_BITS-1:0]                   s2_slow_tier,
    output logic [tpp_pkg::KEY_BITS-1:0]              s2_key,
    output logic [BYTE_COUNT_BITS-1:0]                s2_size,
    output logic                                      s2_in_fast,
    output logic [tpp_pkg::COPY_BITS-1:0]             s2_copies,
    output logic [TIER_ID_BITS-1:0]                   s2_first
);

    localparam int PROD_BITS = BYTE_COUNT_BITS + tpp_pkg::WM_BITS;

    logic                 s2_valid_reg;
    logic                 s2_valid_next;
    logic [PROD_BITS-1:0] high_prod_next;
    logic [PROD_BITS-1:0] low_prod_next;

    always_comb
    begin
        high_prod_next = PROD_BITS'(s1_total) * PROD_BITS'(cfg.high_wm);
        low_prod_next  = PROD_BITS'(s1_total) * PROD_BITS'(cfg.low_wm);
        s2_valid_next  = s2_ready ? s1_valid : s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid)
        begin
            s2_command      <= s1_command;
            s2_used         <= s1_used;
            s2_total_zero   <= (s1_total == '0);
            s2_high_prod    <= high_prod_next;
            s2_low_prod     <= low_prod_next;
            s2_fast_stats   <= s1_fast_stats;
            s2_slow_present <= s1_slow_present;
            s2_slow_tier    <= s1_slow_tier;
            s2_key          <= s1_key;
            s2_size         <= s1_size;
            s2_in_fast      <= s1_in_fast;
            s2_copies       <= s1_copies;
            s2_first        <= s1_first;
        end
    end

    assign s2_valid = s2_valid_reg;

endmodule

`default_nettype wire

@@ src/tpp_plan_core.sv @@
// Final stage: batch state, admission sum, action choice and result register.
// Depends on tpp_pkg.
`default_nettype none

module tpp_plan_core #(
    parameter int TIER_ID_BITS    = tpp_pkg::TIER_ID_BITS_DEF,
    parameter int BYTE_COUNT_BITS = tpp_pkg::BYTE_COUNT_BITS_DEF
) (
    input  wire                                         clk,
    input  wire                                         rst_n,
    input  tpp_pkg::cfg_t                               cfg,
    input  wire                                         s2_valid,
    output logic                                        s2_ready,
    input  wire                                         s2_command,
    input  wire  [BYTE_COUNT_BITS-1:0]                  s2_used,
    input  wire                                         s2_total_zero,
    input  wire  [BYTE_COUNT_BITS+tpp_pkg::WM_BITS-1:0] s2_high_prod,
    input  wire  [BYTE_COUNT_BITS+tpp_pkg::WM_BITS-1:0] s2_low_prod,
    input  wire                                         s2_fast_stats,
    input  wire                                         s2_slow_present,
    input  wire  [TIER_ID_BITS-1:0]                     s2_slow_tier,
    input  wire  [tpp_pkg::KEY_BITS-1:0]                s2_key,
    input  wire  [BYTE_COUNT_BITS-1:0]                  s2_size,
    input  wire                                         s2_in_fast,
    input  wire  [tpp_pkg::COPY_BITS-1:0]               s2_copies,
    input  wire  [TIER_ID_BITS-1:0]                     s2_first,
    output logic                                        out_valid,
    input  wire                                         out_stall,
    output logic [1:0]                                  action,
    output logic [1:0]                                  status,
    output logic [tpp_pkg::KEY_BITS-1:0]                key_out,
    output logic [TIER_ID_BITS-1:0]                     source_tier,
    output logic [TIER_ID_BITS-1:0]                     target_tier
);

    localparam int PROD_BITS = BYTE_COUNT_BITS + tpp_pkg::WM_BITS;

    logic                         batch_ok_reg, batch_ok_next;
    logic                         above_high_reg, above_high_next;
    logic                         pre_demote_reg, pre_demote_next;
    logic [BYTE_COUNT_BITS-1:0]   target_usage_reg, target_usage_next;
    logic [BYTE_COUNT_BITS-1:0]   accumulated_reg, accumulated_next;
    logic                         slow_valid_reg, slow_valid_next;
    logic [TIER_ID_BITS-1:0]      slow_id_reg, slow_id_next;
    logic                         out_valid_reg, out_valid_next;

    logic [TIER_ID_BITS-1:0]      fast;
    logic [PROD_BITS-1:0]         used_scaled;
    logic                         begin_high;
    logic                         begin_low;
    tpp_pkg::status_t             begin_status;
    logic                         slow_ok;
    logic [BYTE_COUNT_BITS:0]     sum;
    logic                         fits;
    logic                         other;
    logic                         take;

    tpp_pkg::action_t             act_next;
    tpp_pkg::status_t             st_next;
    logic [tpp_pkg::KEY_BITS-1:0] key_next;
    logic [TIER_ID_BITS-1:0]      src_next;
    logic [TIER_ID_BITS-1:0]      dst_next;

    assign s2_ready = !out_valid_reg || !out_stall;
    assign take     = s2_valid && s2_ready;

    always_comb
    begin
        fast        = TIER_ID_BITS'(cfg.fast_tier_id);
        used_scaled = {1'b0, s2_used, {tpp_pkg::WM_FRAC_BITS{1'b0}}};
        begin_high  = used_scaled > s2_high_prod;
        begin_low   = used_scaled > s2_low_prod;
        slow_ok     = s2_slow_present && (s2_slow_tier != fast);
        sum         = {1'b0, accumulated_reg} + {1'b0, s2_size};
        fits        = sum <= {1'b0, target_usage_reg};
        other       = s2_copies > tpp_pkg::COPY_BITS'(1);

        if (!cfg.fast_tier_set)
            begin_status = tpp_pkg::ST_BAD_PARAMS;
        else if (!s2_fast_stats)
            begin_status = tpp_pkg::ST_NO_TIER;
        else if (s2_total_zero)
            begin_status = tpp_pkg::ST_BAD_PARAMS;
        else
            begin_status = tpp_pkg::ST_OK;
    end

    // batch state
    always_comb
    begin
        batch_ok_next     = batch_ok_reg;
        above_high_next   = above_high_reg;
        pre_demote_next   = pre_demote_reg;
        target_usage_next = target_usage_reg;
        accumulated_next  = accumulated_reg;
        slow_valid_next   = slow_valid_reg;
        slow_id_next      = slow_id_reg;
        if (take)
        begin
            if (s2_command == tpp_pkg::CMD_BEGIN)
            begin
                accumulated_next = '0;
                if (begin_status == tpp_pkg::ST_OK)
                begin
                    batch_ok_next     = 1'b1;
                    above_high_next   = begin_high;
                    pre_demote_next   = begin_low && !begin_high;
                    target_usage_next =
                        s2_low_prod[tpp_pkg::WM_FRAC_BITS +: BYTE_COUNT_BITS];
                    slow_valid_next   = slow_ok;
                    slow_id_next      = slow_ok ? s2_slow_tier : '0;
                end
                else
                begin
                    batch_ok_next     = 1'b0;
                    above_high_next   = 1'b0;
                    pre_demote_next   = 1'b0;
                    target_usage_next = '0;
                    slow_valid_next   = 1'b0;
                    slow_id_next      = '0;
                end
            end
            else if (batch_ok_reg && fits)
            begin
                accumulated_next = sum[BYTE_COUNT_BITS-1:0];
            end
        end
    end

    // result choice
    always_comb
    begin
        act_next = tpp_pkg::ACT_NONE;
        st_next  = tpp_pkg::ST_OK;
        key_next = s2_key;
        src_next = '0;
        dst_next = '0;
        if (s2_command == tpp_pkg::CMD_BEGIN)
        begin
            st_next  = begin_status;
            key_next = '0;
        end
        else if (!batch_ok_reg)
        begin
            act_next = tpp_pkg::ACT_NONE;
        end
        else if (s2_in_fast && !fits)
        begin
            if (above_high_reg)
            begin
                src_next = fast;
                if (!other && slow_valid_reg)
                begin
                    act_next = tpp_pkg::ACT_MIGRATE;
                    dst_next = slow_id_reg;
                end
                else
                begin
                    act_next = tpp_pkg::ACT_EVICT;
                end
            end
            else if (pre_demote_reg && !other && slow_valid_reg)
            begin
                act_next = tpp_pkg::ACT_REPLICATE;
                src_next = fast;
                dst_next = slow_id_reg;
            end
        end
        else if (s2_in_fast || !fits || pre_demote_reg)
        begin
            act_next = tpp_pkg::ACT_NONE;
        end
        else if (s2_copies == '0)
        begin
            st_next = tpp_pkg::ST_NO_REPLICA;
        end
        else
        begin
            act_next = tpp_pkg::ACT_MIGRATE;
            src_next = s2_first;
            dst_next = fast;
        end
    end

    always_comb
    begin
        out_valid_next = s2_ready ? s2_valid : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_ok_reg     <= 1'b0;
            above_high_reg   <= 1'b0;
            pre_demote_reg   <= 1'b0;
            target_usage_reg <= '0;
            accumulated_reg  <= '0;
            slow_valid_reg   <= 1'b0;
            slow_id_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            batch_ok_reg     <= batch_ok_next;
            above_high_reg   <= above_high_next;
            pre_demote_reg   <= pre_demote_next;
            target_usage_reg <= target_usage_next;
            accumulated_reg  <= accumulated_next;
            slow_valid_reg   <= slow_valid_next;
            slow_id_reg      <= slow_id_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            action      <= act_next;
            status      <= st_next;
            key_out     <= key_next;
            source_tier <= src_next;
            target_tier <= dst_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ src/tier_placement_planner.sv @@
// Tier placement planner: one request per clock while in_stall is low, one result per request;
// each accepted request passes through the input register, the watermark product register and
// the result register. The begin request's two capacity-by-watermark products are
// set by the middle stage's multipliers; key requests need only the running-sum add and
// compare in the last stage, which also carries the batch state from one request to the next.
// Depends on tpp_pkg, tpp_ratio_stage, tpp_plan_core and the assertion macro header.
`default_nettype none

`include "tier_placement_planner_defines.svh"

module tier_placement_planner #(
    parameter int TIER_ID_BITS    = tpp_pkg::TIER_ID_BITS_DEF,
    parameter int BYTE_COUNT_BITS = tpp_pkg::BYTE_COUNT_BITS_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_we,
    input  wire  [tpp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire  [tpp_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  wire                                 in_valid,
    output logic                                in_stall,
    input  wire                                 command,
    input  wire  [BYTE_COUNT_BITS-1:0]          used_bytes,
    input  wire  [BYTE_COUNT_BITS-1:0]          total_bytes,
    input  wire                                 fast_stats_present,
    input  wire                                 slow_present,
    input  wire  [TIER_ID_BITS-1:0]             slow_tier,
    input  wire  [tpp_pkg::KEY_BITS-1:0]        key_handle,
    input  wire  [BYTE_COUNT_BITS-1:0]          data_size,
    input  wire                                 in_fast,
    input  wire  [tpp_pkg::COPY_BITS-1:0]       copy_count,
    input  wire  [TIER_ID_BITS-1:0]             first_location,
    output logic                                out_valid,
    input  wire                                 out_stall,
    output logic [1:0]                          action,
    output logic [1:0]                          status,
    output logic [tpp_pkg::KEY_BITS-1:0]        key_out,
    output logic [TIER_ID_BITS-1:0]             source_tier,
    output logic [TIER_ID_BITS-1:0]             target_tier
);

    localparam int PROD_BITS = BYTE_COUNT_BITS + tpp_pkg::WM_BITS;

    tpp_pkg::cfg_t                   cfg_reg;
    tpp_pkg::cfg_t                   cfg_next;
    logic [tpp_pkg::WM_BITS-1:0]     wm_sat;

    logic                            s1_valid_reg, s1_valid_next;
    logic                            s1_command_reg;
    logic [BYTE_COUNT_BITS-1:0]      s1_used_reg;
    logic [BYTE_COUNT_BITS-1:0]      s1_total_reg;
    logic                            s1_fast_stats_reg;
    logic                            s1_slow_present_reg;
    logic [TIER_ID_BITS-1:0]         s1_slow_tier_reg;
    logic [tpp_pkg::KEY_BITS-1:0]    s1_key_reg;
    logic [BYTE_COUNT_BITS-1:0]      s1_size_reg;
    logic                            s1_in_fast_reg;
    logic [tpp_pkg::COPY_BITS-1:0]   s1_copies_reg;
    logic [TIER_ID_BITS-1:0]         s1_first_reg;

    logic                            s2_valid;
    logic                            s2_ready;
    logic                            s2_command;
    logic [BYTE_COUNT_BITS-1:0]      s2_used;
    logic                            s2_total_zero;
    logic [PROD_BITS-1:0]            s2_high_prod;
    logic [PROD_BITS-1:0]            s2_low_prod;
    logic                            s2_fast_stats;
    logic                            s2_slow_present;
    logic [TIER_ID_BITS-1:0]         s2_slow_tier;
    logic [tpp_pkg::KEY_BITS-1:0]    s2_key;
    logic [BYTE_COUNT_BITS-1:0]      s2_size;
    logic                            s2_in_fast;
    logic [tpp_pkg::COPY_BITS-1:0]   s2_copies;
    logic [TIER_ID_BITS-1:0]         s2_first;

    // saturate watermarks to one
    always_comb
    begin
        wm_sat   = (cfg_data > tpp_pkg::WM_ONE) ? tpp_pkg::WM_ONE : cfg_data;
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (tpp_pkg::cfg_index_t'(cfg_index))
                tpp_pkg::CFG_FAST_TIER_ID:
                    cfg_next.fast_tier_id = cfg_data[tpp_pkg::FAST_ID_BITS-1:0];
                tpp_pkg::CFG_FAST_TIER_SET:
                    cfg_next.fast_tier_set = cfg_data[0];
                tpp_pkg::CFG_HIGH_WM:
                    cfg_next.high_wm = wm_sat;
                tpp_pkg::CFG_LOW_WM:
                    cfg_next.low_wm = wm_sat;
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fast_tier_id  <= '0;
            cfg_reg.fast_tier_set <= 1'b0;
            cfg_reg.high_wm       <= tpp_pkg::HIGH_WM_RESET;
            cfg_reg.low_wm        <= tpp_pkg::LOW_WM_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_stall = s1_valid_reg && !s2_ready;

    always_comb
    begin
        s1_valid_next = in_stall ? s1_valid_reg : in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_command_reg      <= command;
            s1_used_reg         <= used_bytes;
            s1_total_reg        <= total_bytes;
            s1_fast_stats_reg   <= fast_stats_present;
            s1_slow_present_reg <= slow_present;
            s1_slow_tier_reg    <= slow_tier;
            s1_key_reg          <= key_handle;
            s1_size_reg         <= data_size;
            s1_in_fast_reg      <= in_fast;
            s1_copies_reg       <= copy_count;
            s1_first_reg        <= first_location;
        end
    end

    tpp_ratio_stage #(
        .TIER_ID_BITS    (TIER_ID_BITS),
        .BYTE_COUNT_BITS (BYTE_COUNT_BITS)
    ) u_ratio (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .s1_valid        (s1_valid_reg),
        .s2_ready        (s2_ready),
        .s1_command      (s1_command_reg),
        .s1_used         (s1_used_reg),
        .s1_total        (s1_total_reg),
        .s1_fast_stats   (s1_fast_stats_reg),
        .s1_slow_present (s1_slow_present_reg),
        .s1_slow_tier    (s1_slow_tier_reg),
        .s1_key          (s1_key_reg),
        .s1_size         (s1_size_reg),
        .s1_in_fast      (s1_in_fast_reg),
        .s1_copies       (s1_copies_reg),
        .s1_first        (s1_first_reg),
        .s2_valid        (s2_valid),
        .s2_command      (s2_command),
        .s2_used         (s2_used),
        .s2_total_zero   (s2_total_zero),
        .s2_high_prod    (s2_high_prod),
        .s2_low_prod     (s2_low_prod),
        .s2_fast_stats   (s2_fast_stats),
        .s2_slow_present (s2_slow_present),
        .s2_slow_tier    (s2_slow_tier),
        .s2_key          (s2_key),
        .s2_size         (s2_size),
        .s2_in_fast      (s2_in_fast),
        .s2_copies       (s2_copies),
        .s2_first        (s2_first)
    );

    tpp_plan_core #(
        .TIER_ID_BITS    (TIER_ID_BITS),
        .BYTE_COUNT_BITS (BYTE_COUNT_BITS)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .s2_valid        (s2_valid),
        .s2_ready        (s2_ready),
        .s2_command      (s2_command),
        .s2_used         (s2_used),
        .s2_total_zero   (s2_total_zero),
        .s2_high_prod    (s2_high_prod),
        .s2_low_prod     (s2_low_prod),
        .s2_fast_stats   (s2_fast_stats),
        .s2_slow_present (s2_slow_present),
        .s2_slow_tier    (s2_slow_tier),
        .s2_key          (s2_key),
        .s2_size         (s2_size),
        .s2_in_fast      (s2_in_fast),
        .s2_copies       (s2_copies),
        .s2_first        (s2_first),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .action          (action),
        .status          (status),
        .key_out         (key_out),
        .source_tier     (source_tier),
        .target_tier     (target_tier)
    );

    `TPP_ASSERT_NOW(a_error_no_action, out_valid && (status != tpp_pkg::ST_OK), action == tpp_pkg::ACT_NONE, "action on failed request")
    `TPP_ASSERT_NOW(a_evict_no_target, out_valid && (action == tpp_pkg::ACT_EVICT), target_tier == '0, "evict with target tier")
    `TPP_ASSERT_NEXT(a_accept_loads_s1, in_valid && !in_stall, s1_valid_reg, "accepted request lost")
    `TPP_ASSERT_NEXT(a_s2_holds, s2_valid && !s2_ready, s2_valid, "stalled stage dropped request")

endmodule

`default_nettype wire

@@ tb/sv/tpp_plan_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the tier placement planner: follows the config port and the request
// and result channels, predicts each planned action and compares results in order.
// Depends on tpp_pkg.
module tpp_plan_checker #(
    parameter int TIER_ID_BITS    = tpp_pkg::TIER_ID_BITS_DEF,
    parameter int BYTE_COUNT_BITS = tpp_pkg::BYTE_COUNT_BITS_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_we,
    input  wire  [tpp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire  [tpp_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  wire                                 in_valid,
    input  wire                                 in_stall,
    input  wire                                 command,
    input  wire  [BYTE_COUNT_BITS-1:0]          used_bytes,
    input  wire  [BYTE_COUNT_BITS-1:0]          total_bytes,
    input  wire                                 fast_stats_present,
    input  wire                                 slow_present,
    input  wire  [TIER_ID_BITS-1:0]             slow_tier,
    input  wire  [tpp_pkg::KEY_BITS-1:0]        key_handle,
    input  wire  [BYTE_COUNT_BITS-1:0]          data_size,
    input  wire                                 in_fast,
    input  wire  [tpp_pkg::COPY_BITS-1:0]       copy_count,
    input  wire  [TIER_ID_BITS-1:0]             first_location,
    input  wire                                 out_valid,
    input  wire                                 out_stall,
    input  wire  [1:0]                          action,
    input  wire  [1:0]                          status,
    input  wire  [tpp_pkg::KEY_BITS-1:0]        key_out,
    input  wire  [TIER_ID_BITS-1:0]             source_tier,
    input  wire  [TIER_ID_BITS-1:0]             target_tier,
    output int                                  mismatches,
    output int                                  pending
);
    import tpp_pkg::*;

    localparam int PW = BYTE_COUNT_BITS + 18;

    typedef struct packed {
        action_t                 act;
        status_t                 st;
        logic [KEY_BITS-1:0]     key;
        logic [TIER_ID_BITS-1:0] src;
        logic [TIER_ID_BITS-1:0] dst;
    } plan_t;

    logic [FAST_ID_BITS-1:0]    fast_id;
    logic                       fast_set;
    logic [WM_BITS-1:0]         high_wm;
    logic [WM_BITS-1:0]         low_wm;

    logic                       batch_open;
    logic                       over_high;
    logic                       in_band;
    logic [BYTE_COUNT_BITS-1:0] budget;
    logic [BYTE_COUNT_BITS:0]   admitted;
    logic                       slow_ok;
    logic [TIER_ID_BITS-1:0]    slow_sel;

    plan_t planned_q[$];

    // used / total > wm / 2^16, exact
    function automatic logic above_ratio(input logic [BYTE_COUNT_BITS-1:0] used,
                                         input logic [BYTE_COUNT_BITS-1:0] total,
                                         input logic [WM_BITS-1:0] wm);
        logic [PW-1:0] lhs;
        logic [PW-1:0] rhs;
        lhs = PW'(used) << WM_FRAC_BITS;
        rhs = PW'(wm) * PW'(total);
        return lhs > rhs;
    endfunction

    function automatic plan_t predict_plan();
        plan_t                      p;
        logic [PW-1:0]              prod;
        logic [BYTE_COUNT_BITS+1:0] sum;
        logic                       fits;
        logic                       other;
        logic [TIER_ID_BITS-1:0]    fast;
        p = '0;
        fast = TIER_ID_BITS'(fast_id);
        if (command == CMD_BEGIN)
        begin
            if (!fast_set)
                p.st = ST_BAD_PARAMS;
            else if (!fast_stats_present)
                p.st = ST_NO_TIER;
            else if (total_bytes == '0)
                p.st = ST_BAD_PARAMS;
            else
                p.st = ST_OK;
            batch_open = (p.st == ST_OK);
            admitted = '0;
            if (batch_open)
            begin
                over_high = above_ratio(used_bytes, total_bytes, high_wm);
                in_band = above_ratio(used_bytes, total_bytes, low_wm) && !over_high;
                prod = PW'(total_bytes) * PW'(low_wm);
                budget = prod[BYTE_COUNT_BITS+WM_FRAC_BITS-1:WM_FRAC_BITS];
                slow_ok = slow_present && (slow_tier != fast);
                slow_sel = slow_ok ? slow_tier : '0;
            end
            else
            begin
                over_high = 1'b0;
                in_band = 1'b0;
                budget = '0;
                slow_ok = 1'b0;
                slow_sel = '0;
            end
            return p;
        end
        p.key = key_handle;
        if (!batch_open)
            return p;
        sum = (BYTE_COUNT_BITS+2)'(admitted) + (BYTE_COUNT_BITS+2)'(data_size);
        fits = sum <= (BYTE_COUNT_BITS+2)'(budget);
        if (fits)
            admitted = sum[BYTE_COUNT_BITS:0];
        if (in_fast && !fits)
        begin
            other = copy_count > 1;
            if (over_high)
            begin
                p.src = fast;
                if (!other && slow_ok)
                begin
                    p.act = ACT_MIGRATE;
                    p.dst = slow_sel;
                end
                else
                    p.act = ACT_EVICT;
            end
            else if (in_band && !other && slow_ok)
            begin
                p.act = ACT_REPLICATE;
                p.src = fast;
                p.dst = slow_sel;
            end
        end
        else if (!in_fast && fits && !in_band)
        begin
            if (copy_count == 0)
                p.st = ST_NO_REPLICA;
            else
            begin
                p.act = ACT_MIGRATE;
                p.src = first_location;
                p.dst = fast;
            end
        end
        return p;
    endfunction

    task automatic flag_mismatch(input string why, input plan_t want, input plan_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected act=%0d st=%0d key=%h src=%0d dst=%0d, got act=%0d st=%0d key=%h src=%0d dst=%0d",
                     $time, why, want.act, want.st, want.key, want.src, want.dst,
                     got.act, got.st, got.key, got.src, got.dst);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        plan_t got;
        plan_t want;
        if (!rst_n)
        begin
            fast_id = '0;
            fast_set = 1'b0;
            high_wm = HIGH_WM_RESET;
            low_wm = LOW_WM_RESET;
            batch_open = 1'b0;
            over_high = 1'b0;
            in_band = 1'b0;
            budget = '0;
            admitted = '0;
            slow_ok = 1'b0;
            slow_sel = '0;
            planned_q.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FAST_TIER_ID:  fast_id = cfg_data[FAST_ID_BITS-1:0];
                    CFG_FAST_TIER_SET: fast_set = cfg_data[0];
                    CFG_HIGH_WM:       high_wm = (cfg_data > WM_ONE) ? WM_ONE : cfg_data;
                    CFG_LOW_WM:        low_wm = (cfg_data > WM_ONE) ? WM_ONE : cfg_data;
                    default:           ;
                endcase
            end
            if (in_valid && !in_stall)
                planned_q.insert(planned_q.size(), predict_plan());
            if (out_valid && !out_stall)
            begin
                got.act = action_t'(action);
                got.st = status_t'(status);
                got.key = key_out;
                got.src = source_tier;
                got.dst = target_tier;
                if (planned_q.size() == 0)
                    flag_mismatch("result with no request pending", '0, got);
                else
                begin
                    want = planned_q.pop_front();
                    if (got != want)
                        flag_mismatch("result mismatch", want, got);
                end
            end
            pending = planned_q.size();
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// Top of the tier placement planner test: clock, reset, config phases and request
// stimulus with random idling on both channels; the verdict comes from tpp_plan_checker.
// Depends on tpp_pkg, tier_placement_planner and tpp_plan_checker.
module testbench;
    import tpp_pkg::*;

    localparam int B = BYTE_COUNT_BITS_DEF;
    localparam int T = TIER_ID_BITS_DEF;
    localparam logic [B-1:0] BYTES_MAX = '1;

    typedef struct packed {
        logic                 cmd;
        logic [B-1:0]         used;
        logic [B-1:0]         total;
        logic                 fsp;
        logic                 sp;
        logic [T-1:0]         slow;
        logic [KEY_BITS-1:0]  key;
        logic [B-1:0]         size;
        logic                 inf;
        logic [COPY_BITS-1:0] copies;
        logic [T-1:0]         first;
    } request_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic                      command;
    logic [B-1:0]              used_bytes;
    logic [B-1:0]              total_bytes;
    logic                      fast_stats_present;
    logic                      slow_present;
    logic [T-1:0]              slow_tier;
    logic [KEY_BITS-1:0]       key_handle;
    logic [B-1:0]              data_size;
    logic                      in_fast;
    logic [COPY_BITS-1:0]      copy_count;
    logic [T-1:0]              first_location;
    logic                      out_valid;
    logic                      out_stall;
    logic [1:0]                action;
    logic [1:0]                status;
    logic [KEY_BITS-1:0]       key_out;
    logic [T-1:0]              source_tier;
    logic [T-1:0]              target_tier;
    int                        mismatches;
    int                        pending;

    bit                        quiet;
    logic [T-1:0]              fast_now;

    tier_placement_planner dut (.*);

    tpp_plan_checker plan_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tier_placement_planner test failed");
        $finish;
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall = !quiet && ($urandom_range(99) < 7);
        end
    end

    function automatic logic [B-1:0] rand_bytes();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[B-1:0] >> $urandom_range(0, B - 1);
    endfunction

    function automatic logic [WM_BITS-1:0] pick_wm();
        if ($urandom_range(3) == 0)
            return WM_BITS'($urandom);
        return WM_BITS'($urandom_range(0, 65536));
    endfunction

    function automatic request_t noise();
        request_t r;
        r.cmd = 1'($urandom);
        r.used = B'({$urandom, $urandom});
        r.total = B'({$urandom, $urandom});
        r.fsp = 1'($urandom);
        r.sp = 1'($urandom);
        r.slow = T'($urandom);
        r.key = $urandom;
        r.size = B'({$urandom, $urandom});
        r.inf = 1'($urandom);
        r.copies = COPY_BITS'($urandom);
        r.first = T'($urandom);
        return r;
    endfunction

    function automatic request_t begin_req(input logic [B-1:0] used, input logic [B-1:0] total,
                                           input logic fsp, input logic sp,
                                           input logic [T-1:0] slow);
        request_t r;
        r = noise();
        r.cmd = CMD_BEGIN;
        r.used = used;
        r.total = total;
        r.fsp = fsp;
        r.sp = sp;
        r.slow = slow;
        return r;
    endfunction

    function automatic request_t key_req(input logic [KEY_BITS-1:0] key,
                                         input logic [B-1:0] size, input logic inf,
                                         input logic [COPY_BITS-1:0] copies,
                                         input logic [T-1:0] first);
        request_t r;
        r = noise();
        r.cmd = CMD_KEY;
        r.key = key;
        r.size = size;
        r.inf = inf;
        r.copies = copies;
        r.first = first;
        return r;
    endfunction

    task automatic send_request(input request_t r);
        @(negedge clk);
        while (!quiet && ($urandom_range(99) < 7))
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        command = r.cmd;
        used_bytes = r.used;
        total_bytes = r.total;
        fast_stats_present = r.fsp;
        slow_present = r.sp;
        slow_tier = r.slow;
        key_handle = r.key;
        data_size = r.size;
        in_fast = r.inf;
        copy_count = r.copies;
        first_location = r.first;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // drop valid and let every pending result arrive
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        wait (pending == 0);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_config(input logic [T-1:0] fast, input logic set,
                              input logic [WM_BITS-1:0] hw, input logic [WM_BITS-1:0] lw);
        drain();
        write_reg(CFG_FAST_TIER_ID, CFG_DATA_BITS'(fast));
        write_reg(CFG_FAST_TIER_SET, CFG_DATA_BITS'(set));
        write_reg(CFG_HIGH_WM, hw);
        write_reg(CFG_LOW_WM, lw);
        fast_now = fast;
    endtask

    task automatic run_phase(input int n);
        int                   sent;
        int                   keys;
        logic [B-1:0]         total;
        logic [B-1:0]         used;
        logic [B-1:0]         size;
        logic [65:0]          scaled;
        logic [T-1:0]         slow;
        logic [COPY_BITS-1:0] copies;
        logic [T-1:0]         first;
        sent = 0;
        while (sent < n)
        begin
            total = rand_bytes();
            if ($urandom_range(99) < 4)
                total = '0;
            else if (total == '0)
                total = B'(1);
            case ($urandom_range(3))
                0: used = rand_bytes();
                3: used = total;
                default:
                begin
                    scaled = (66'(total) * 66'($urandom_range(0, 70000))) >> 16;
                    used = (scaled > 66'(BYTES_MAX)) ? BYTES_MAX : scaled[B-1:0];
                end
            endcase
            slow = ($urandom_range(99) < 20) ? fast_now : T'($urandom);
            send_request(begin_req(used, total, $urandom_range(99) < 92,
                                   $urandom_range(99) < 85, slow));
            sent++;
            keys = $urandom_range(1, 24);
            if (keys > n - sent)
                keys = n - sent;
            repeat (keys)
            begin
                case ($urandom_range(9))
                    0: size = '0;
                    1: size = rand_bytes();
                    default: size = (total >> $urandom_range(1, 6)) + B'($urandom_range(0, 255));
                endcase
                if ($urandom_range(9) < 6)
                    copies = COPY_BITS'($urandom_range(0, 2));
                else
                    copies = COPY_BITS'($urandom_range(0, 15));
                first = ($urandom_range(9) == 0) ? fast_now : T'($urandom);
                send_request(key_req($urandom, size, 1'($urandom), copies, first));
                sent++;
            end
        end
    endtask

    initial
    begin
        quiet = 1'b0;
        fast_now = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        command = CMD_BEGIN;
        used_bytes = '0;
        total_bytes = '0;
        fast_stats_present = 1'b0;
        slow_present = 1'b0;
        slow_tier = '0;
        key_handle = '0;
        data_size = '0;
        in_fast = 1'b0;
        copy_count = '0;
        first_location = '0;
        rst_n = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // no fast tier configured yet, then a key with no open batch
        send_request(begin_req(48'd10, 48'd100, 1'b1, 1'b1, 8'd9));
        send_request(key_req(32'h1234_5678, 48'd1, 1'b0, 4'd1, 8'd3));

        set_config(8'd5, 1'b1, HIGH_WM_RESET, LOW_WM_RESET);
        send_request(begin_req(48'd10, 48'd100, 1'b0, 1'b1, 8'd9));
        send_request(begin_req(48'd10, 48'd0, 1'b1, 1'b1, 8'd9));
        // above the high mark
        send_request(begin_req(48'd95, 48'd100, 1'b1, 1'b1, 8'd9));
        send_request(key_req(32'd1, 48'd200, 1'b1, 4'd1, 8'd5));
        send_request(key_req(32'd2, 48'd200, 1'b1, 4'd3, 8'd5));
        send_request(key_req(32'd3, 48'd10, 1'b0, 4'd2, 8'd7));
        send_request(key_req(32'd4, 48'd10, 1'b0, 4'd0, 8'd7));
        send_request(key_req(32'd5, 48'd10, 1'b1, 4'd1, 8'd5));
        send_request(key_req(32'd6, 48'd1000, 1'b0, 4'd1, 8'd7));
        // pre-demote band, slow tier same as fast
        send_request(begin_req(48'd80, 48'd100, 1'b1, 1'b1, 8'd5));
        send_request(key_req(32'd7, BYTES_MAX, 1'b1, 4'd0, 8'd5));
        send_request(begin_req(48'd80, 48'd100, 1'b1, 1'b1, 8'd200));
        send_request(key_req(32'd8, BYTES_MAX, 1'b1, 4'd1, 8'd5));
        send_request(key_req(32'd9, BYTES_MAX, 1'b1, 4'd2, 8'd5));
        send_request(key_req(32'd10, 48'd1, 1'b0, 4'd1, 8'd7));
        // full tier, no slow tier
        send_request(begin_req(BYTES_MAX, BYTES_MAX, 1'b1, 1'b0, 8'd9));
        send_request(key_req(32'd11, BYTES_MAX, 1'b1, 4'd0, 8'd5));
        send_request(key_req(32'hFFFF_FFFF, 48'd0, 1'b0, 4'd15, 8'd255));
        // empty tier
        send_request(begin_req(48'd0, BYTES_MAX, 1'b1, 1'b1, 8'd255));
        send_request(key_req(32'd12, BYTES_MAX, 1'b0, 4'd1, 8'd7));
        send_request(key_req(32'd13, 48'd0, 1'b1, 4'd1, 8'd5));

        for (int p = 0; p < 10; p++)
        begin
            case (p)
                0: set_config(8'd0, 1'b1, HIGH_WM_RESET, LOW_WM_RESET);
                1: set_config(8'd255, 1'b1, WM_ONE, WM_ONE);
                2: set_config(T'($urandom), 1'b1, 17'd0, 17'd0);
                3: set_config(T'($urandom), 1'b1, 17'h1FFFF, 17'd100000);
                4: set_config(T'($urandom), 1'b0, pick_wm(), pick_wm());
                default: set_config(T'($urandom), 1'b1, pick_wm(), pick_wm());
            endcase
            quiet = (p == 6) || (p == 7);
            run_phase(195);
        end

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("tier_placement_planner test passed");
        else
            $display("tier_placement_planner test failed");
        $finish;
    end

endmodule
